// ===== src/svm_pkg.sv =====
package svm_pkg;

    localparam int unsigned MvWidth    = 16;
    localparam int unsigned ShiftWidth = 4;
    localparam int unsigned CfgAddrW   = 3;

    localparam logic [MvWidth-1:0]    RstWarnLevel  = 16'd11800;
    localparam logic [MvWidth-1:0]    RstClearLevel = 16'd12200;
    localparam logic [MvWidth-1:0]    RstWarnDwell  = 16'd150;
    localparam logic [MvWidth-1:0]    RstRestDwell  = 16'd100;
    localparam logic [ShiftWidth-1:0] RstFiltShift  = 4'd3;
    localparam logic [ShiftWidth-1:0] RstRestShift  = 4'd4;

    typedef enum logic [CfgAddrW-1:0] {
        REG_WARN_LEVEL  = 3'd0,
        REG_CLEAR_LEVEL = 3'd1,
        REG_WARN_DWELL  = 3'd2,
        REG_REST_DWELL  = 3'd3,
        REG_FILT_SHIFT  = 3'd4,
        REG_REST_SHIFT  = 3'd5
    } cfg_addr_t;

    typedef struct packed {
        logic [MvWidth-1:0]    warn_level_mv;
        logic [MvWidth-1:0]    clear_level_mv;
        logic [MvWidth-1:0]    warn_dwell_frames;
        logic [MvWidth-1:0]    rest_dwell_frames;
        logic [ShiftWidth-1:0] filter_shift;
        logic [ShiftWidth-1:0] rest_filter_shift;
    } cfg_t;

    typedef struct packed {
        logic [MvWidth-1:0] meas_mv;
        logic               near_neutral;
    } item_t;

    typedef struct packed {
        logic [MvWidth-1:0] echo_mv;
        logic [MvWidth-1:0] avg_mv;
        logic [MvWidth-1:0] idle_avg_mv;
        logic               low_voltage_warning;
    } result_t;

endpackage

// ===== src/svm_regs.sv =====
module svm_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [svm_pkg::CfgAddrW-1:0]        cfg_addr,
    input  logic [svm_pkg::MvWidth-1:0]         cfg_wdata,
    output svm_pkg::cfg_t                       cfg
);

    svm_pkg::cfg_t cfg_reg;
    svm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                svm_pkg::REG_WARN_LEVEL:  cfg_next.warn_level_mv     = cfg_wdata;
                svm_pkg::REG_CLEAR_LEVEL: cfg_next.clear_level_mv    = cfg_wdata;
                svm_pkg::REG_WARN_DWELL:  cfg_next.warn_dwell_frames = cfg_wdata;
                svm_pkg::REG_REST_DWELL:  cfg_next.rest_dwell_frames = cfg_wdata;
                svm_pkg::REG_FILT_SHIFT:
                    cfg_next.filter_shift = cfg_wdata[svm_pkg::ShiftWidth-1:0];
                svm_pkg::REG_REST_SHIFT:
                    cfg_next.rest_filter_shift = cfg_wdata[svm_pkg::ShiftWidth-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warn_level_mv     <= svm_pkg::RstWarnLevel;
            cfg_reg.clear_level_mv    <= svm_pkg::RstClearLevel;
            cfg_reg.warn_dwell_frames <= svm_pkg::RstWarnDwell;
            cfg_reg.rest_dwell_frames <= svm_pkg::RstRestDwell;
            cfg_reg.filter_shift      <= svm_pkg::RstFiltShift;
            cfg_reg.rest_filter_shift <= svm_pkg::RstRestShift;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/svm_shift_avg.sv =====
module svm_shift_avg
(
    input  logic [svm_pkg::MvWidth-1:0]    prev,
    input  logic [svm_pkg::MvWidth-1:0]    target,
    input  logic [svm_pkg::ShiftWidth-1:0] shift,
    output logic [svm_pkg::MvWidth-1:0]    avg
);

    // arithmetic shift of the signed difference floors toward minus infinity
    logic signed [svm_pkg::MvWidth:0] diff;
    logic signed [svm_pkg::MvWidth:0] step;
    logic        [svm_pkg::MvWidth:0] sum;

    always_comb
    begin
        diff = $signed({1'b0, target}) - $signed({1'b0, prev});
        step = diff >>> shift;
        sum  = {1'b0, prev} + $unsigned(step);
        avg  = sum[svm_pkg::MvWidth-1:0];
    end

endmodule

// ===== src/svm_core.sv =====
module svm_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  svm_pkg::item_t  item,
    input  svm_pkg::cfg_t   cfg,
    output svm_pkg::result_t res
);

    localparam int unsigned W = svm_pkg::MvWidth;

    logic         seeded_reg,    seeded_next;
    logic [W-1:0] filt_reg,      filt_next;
    logic [W-1:0] rest_reg,      rest_next;
    logic [W-1:0] low_cnt_reg,   low_cnt_next;
    logic [W-1:0] neu_cnt_reg,   neu_cnt_next;
    logic         warn_reg,      warn_next;

    logic [W-1:0] filt_avg;
    logic [W-1:0] rest_base;
    logic [W-1:0] rest_avg;
    logic [W-1:0] low_inc;
    logic [W-1:0] neu_inc;

    svm_shift_avg u_filt_avg
    (
        .prev   (filt_reg),
        .target (item.meas_mv),
        .shift  (cfg.filter_shift),
        .avg    (filt_avg)
    );

    svm_shift_avg u_rest_avg
    (
        .prev   (rest_base),
        .target (filt_next),
        .shift  (cfg.rest_filter_shift),
        .avg    (rest_avg)
    );

    always_comb
    begin
        seeded_next = 1'b1;
        filt_next   = seeded_reg ? filt_avg : item.meas_mv;
        rest_base   = seeded_reg ? rest_reg : item.meas_mv;

        low_inc      = (low_cnt_reg < cfg.warn_dwell_frames) ? low_cnt_reg + 1'b1 : low_cnt_reg;
        low_cnt_next = low_cnt_reg;
        warn_next    = warn_reg;
        // below-warn test wins when the levels cross
        if (filt_next < cfg.warn_level_mv)
        begin
            low_cnt_next = low_inc;
            if (low_inc >= cfg.warn_dwell_frames)
            begin
                warn_next = 1'b1;
            end
        end
        else if (filt_next >= cfg.clear_level_mv)
        begin
            low_cnt_next = '0;
            warn_next    = 1'b0;
        end

        neu_inc   = (neu_cnt_reg < cfg.rest_dwell_frames) ? neu_cnt_reg + 1'b1 : neu_cnt_reg;
        rest_next = rest_base;
        if (!item.near_neutral)
        begin
            neu_cnt_next = '0;
        end
        else
        begin
            neu_cnt_next = neu_inc;
            if (neu_inc >= cfg.rest_dwell_frames)
            begin
                rest_next = rest_avg;
            end
        end

        res.echo_mv             = item.meas_mv;
        res.avg_mv              = filt_next;
        res.idle_avg_mv         = rest_next;
        res.low_voltage_warning = warn_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg  <= 1'b0;
            filt_reg    <= '0;
            rest_reg    <= '0;
            low_cnt_reg <= '0;
            neu_cnt_reg <= '0;
            warn_reg    <= 1'b0;
        end
        else if (step)
        begin
            seeded_reg  <= seeded_next;
            filt_reg    <= filt_next;
            rest_reg    <= rest_next;
            low_cnt_reg <= low_cnt_next;
            neu_cnt_reg <= neu_cnt_next;
            warn_reg    <= warn_next;
        end
    end

endmodule

// ===== src/supply_voltage_monitor.sv =====
// Channel   Dir  tdata (low bit up)                                  tuser
// s_axis    in   meas_mv[15:0]                                       near_neutral
// m_axis    out  echo_mv, avg_mv, idle_avg_mv (48 bits)              low_voltage_warning
// cfg       in   cfg_addr = register index, cfg_wdata[15:0], written when cfg_we
//
// Two register stages: input register, then result register; the filter and
// warning update sits between them and commits as a request moves on.
// One request per clock sustained while m_tready is held high; m_tvalid rises once
// a taken request moves from the input register into the result register.
// Reset clears the filter state, counters, warning and valid flags, and loads
// the default register settings. A stalled result holds while the input register still
// takes one more request; s_tready drops only when both stages are full.
module supply_voltage_monitor
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // meas_mv
    input  logic                             s_tuser,   // near_neutral

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [47:0]                      m_tdata,   // echo_mv, avg_mv, idle_avg_mv
    output logic                             m_tuser,   // low_voltage_warning

    input  logic                             cfg_we,
    input  logic [svm_pkg::CfgAddrW-1:0]     cfg_addr,
    input  logic [svm_pkg::MvWidth-1:0]      cfg_wdata
);

    svm_pkg::cfg_t    cfg;
    svm_pkg::item_t   in_reg;
    svm_pkg::result_t res;
    svm_pkg::result_t out_reg;

    logic in_valid_reg,  in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic advance;
    logic accept;

    svm_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    svm_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        advance  = in_valid_reg && out_free;
        s_tready = !in_valid_reg || out_free;
        accept   = s_tvalid && s_tready;

        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg.meas_mv      <= s_tdata;
            in_reg.near_neutral <= s_tuser;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.idle_avg_mv, out_reg.avg_mv, out_reg.echo_mv};
    assign m_tuser  = out_reg.low_voltage_warning;

endmodule

// ===== src/svm_checker.sv =====
module svm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an empty output stage never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a fresh result follows an accepted request through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without a request");

    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> m_tdata[15:0] == $past(s_tdata, 2))
        else $error("instant sample not echoed");

endmodule

bind supply_voltage_monitor svm_checker u_svm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/svm_checker.sv =====
module svm_scoreboard
    import svm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [15:0]         s_tdata,    // meas_mv
    input  logic                s_tuser,    // near_neutral

    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [47:0]         m_tdata,    // echo_mv, avg_mv, idle_avg_mv
    input  logic                m_tuser,    // low_voltage_warning

    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [MvWidth-1:0]  cfg_wdata,

    output int unsigned         errors,
    output int unsigned         pending,
    output int unsigned         checked,
    output int unsigned         warn_seen
);

    cfg_t                cfg;
    logic                seeded;
    logic [MvWidth-1:0]  filt_mv;
    logic [MvWidth-1:0]  rest_mv;
    logic [MvWidth-1:0]  low_run;
    logic [MvWidth-1:0]  idle_run;
    logic                warn_active;
    result_t             expected_frames[$];
    result_t             want;

    // Moves prev toward next by floor((next - prev) / 2^sh); shift 0 takes next.
    function automatic logic [MvWidth-1:0] ema_toward(input logic [MvWidth-1:0] prev,
                                                      input logic [MvWidth-1:0] next,
                                                      input logic [ShiftWidth-1:0] sh);
        int unsigned step;
        if (sh == '0)
            return next;
        if (next >= prev)
        begin
            step = (32'(next) - 32'(prev)) >> sh;
            return prev + MvWidth'(step);
        end
        // rounding toward minus infinity on the way down
        step = (32'(prev) - 32'(next) + (32'd1 << sh) - 32'd1) >> sh;
        return prev - MvWidth'(step);
    endfunction

    function automatic void advance_monitor(input logic [MvWidth-1:0] sample,
                                            input logic neutral);
        result_t r;
        if (!seeded)
        begin
            seeded  = 1'b1;
            filt_mv = sample;
            rest_mv = sample;
        end
        else
        begin
            filt_mv = ema_toward(filt_mv, sample, cfg.filter_shift);
        end

        // below-warn test first, so it wins when the levels cross
        if (filt_mv < cfg.warn_level_mv)
        begin
            if (low_run < cfg.warn_dwell_frames)
                low_run++;
            if (low_run >= cfg.warn_dwell_frames)
                warn_active = 1'b1;
        end
        else if (filt_mv >= cfg.clear_level_mv)
        begin
            low_run     = '0;
            warn_active = 1'b0;
        end

        if (!neutral)
        begin
            idle_run = '0;
        end
        else
        begin
            if (idle_run < cfg.rest_dwell_frames)
                idle_run++;
            if (idle_run >= cfg.rest_dwell_frames)
                rest_mv = ema_toward(rest_mv, filt_mv, cfg.rest_filter_shift);
        end

        r.echo_mv             = sample;
        r.avg_mv              = filt_mv;
        r.idle_avg_mv         = rest_mv;
        r.low_voltage_warning = warn_active;
        expected_frames.push_back(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.warn_level_mv     = RstWarnLevel;
            cfg.clear_level_mv    = RstClearLevel;
            cfg.warn_dwell_frames = RstWarnDwell;
            cfg.rest_dwell_frames = RstRestDwell;
            cfg.filter_shift      = RstFiltShift;
            cfg.rest_filter_shift = RstRestShift;
            seeded      = 1'b0;
            filt_mv     = '0;
            rest_mv     = '0;
            low_run     = '0;
            idle_run    = '0;
            warn_active = 1'b0;
            expected_frames.delete();
            errors    = 0;
            pending   = 0;
            checked   = 0;
            warn_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("result with no request pending: tdata=%h tuser=%b",
                           m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    checked++;
                    if (m_tuser)
                        warn_seen++;
                    if (m_tdata[15:0] !== want.echo_mv)
                    begin
                        $error("echo_mv: expected %0d, got %0d",
                               want.echo_mv, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[31:16] !== want.avg_mv)
                    begin
                        $error("avg_mv: expected %0d, got %0d",
                               want.avg_mv, m_tdata[31:16]);
                        errors++;
                    end
                    if (m_tdata[47:32] !== want.idle_avg_mv)
                    begin
                        $error("idle_avg_mv: expected %0d, got %0d",
                               want.idle_avg_mv, m_tdata[47:32]);
                        errors++;
                    end
                    if (m_tuser !== want.low_voltage_warning)
                    begin
                        $error("low_voltage_warning: expected %0d, got %0d",
                               want.low_voltage_warning, m_tuser);
                        errors++;
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_WARN_LEVEL:  cfg.warn_level_mv     = cfg_wdata;
                    REG_CLEAR_LEVEL: cfg.clear_level_mv    = cfg_wdata;
                    REG_WARN_DWELL:  cfg.warn_dwell_frames = cfg_wdata;
                    REG_REST_DWELL:  cfg.rest_dwell_frames = cfg_wdata;
                    REG_FILT_SHIFT:  cfg.filter_shift      = cfg_wdata[ShiftWidth-1:0];
                    REG_REST_SHIFT:  cfg.rest_filter_shift = cfg_wdata[ShiftWidth-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                advance_monitor(s_tdata, s_tuser);

            pending = expected_frames.size();
        end
    end

endmodule

// ===== tb/tb_supply_voltage_monitor.sv =====
module tb_supply_voltage_monitor;

    import svm_pkg::*;

    localparam logic [CfgAddrW-1:0] RegSpare6 = 3'd6;
    localparam logic [CfgAddrW-1:0] RegSpare7 = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n;

    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;     // meas_mv
    logic                s_tuser;     // near_neutral

    logic                m_tvalid;
    logic                m_tready;
    logic [47:0]         m_tdata;     // echo_mv, avg_mv, idle_avg_mv
    logic                m_tuser;     // low_voltage_warning

    logic                cfg_we;
    logic [CfgAddrW-1:0] cfg_addr;
    logic [MvWidth-1:0]  cfg_wdata;

    int unsigned         errors;
    int unsigned         pending;
    int unsigned         checked;
    int unsigned         warn_seen;

    int unsigned         sent;
    int unsigned         settings;
    logic [MvWidth-1:0]  cur_warn;
    logic [MvWidth-1:0]  cur_clear;
    logic                long_hold_req;

    always #5 clk = ~clk;

    supply_voltage_monitor DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    svm_scoreboard u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .warn_seen (warn_seen)
    );

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_sample(input logic [15:0] mv, input logic neutral);
        s_tvalid = 1'b1;
        s_tdata  = mv;
        s_tuser  = neutral;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain_monitor();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [15:0] value);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_config(input logic [15:0] warn_mv, input logic [15:0] clr_mv,
                              input logic [15:0] warn_dwell, input logic [15:0] rest_dwell,
                              input logic [3:0] filt_sh, input logic [3:0] rest_sh);
        write_reg(REG_WARN_LEVEL, warn_mv);
        write_reg(REG_CLEAR_LEVEL, clr_mv);
        write_reg(REG_WARN_DWELL, warn_dwell);
        write_reg(REG_REST_DWELL, rest_dwell);
        // junk in the upper bits must be dropped by the 4-bit registers
        write_reg(REG_FILT_SHIFT, (16'($urandom) & 16'hFFF0) | 16'(filt_sh));
        write_reg(REG_REST_SHIFT, (16'($urandom) & 16'hFFF0) | 16'(rest_sh));
        cur_warn  = warn_mv;
        cur_clear = clr_mv;
        settings++;
    endtask

    // Voltage walks between sag, hysteresis band and healthy levels, with spikes.
    task automatic run_random(input int unsigned count);
        int unsigned done_cnt;
        int unsigned burst;
        int unsigned b;
        int unsigned seg_left;
        int unsigned neutral_left;
        int          level;
        int          sample_i;
        logic        neutral;
        done_cnt     = 0;
        seg_left     = 0;
        neutral_left = 0;
        neutral      = 1'b0;
        level        = 0;
        while (done_cnt < count)
        begin
            burst = $urandom_range(24, 1);
            for (b = 0; b < burst && done_cnt < count; b++)
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(30, 4);
                    case ($urandom_range(4))
                        0:       level = int'(cur_warn) - int'($urandom_range(600));
                        1:       level = (int'(cur_warn) + int'(cur_clear)) / 2;
                        2:       level = int'(cur_clear) + int'($urandom_range(600));
                        3:       level = int'(cur_warn) - 3000;
                        default: level = int'($urandom_range(16'hFFFF));
                    endcase
                end
                seg_left--;
                if (neutral_left == 0)
                begin
                    neutral      = ~neutral;
                    neutral_left = $urandom_range(20, 1);
                end
                neutral_left--;
                if ($urandom_range(99) < 10)
                    sample_i = int'($urandom_range(16'hFFFF));
                else
                    sample_i = level + int'($urandom_range(300)) - 150;
                if (sample_i < 0)
                    sample_i = 0;
                if (sample_i > 65535)
                    sample_i = 65535;
                send_sample(16'(sample_i), neutral);
                done_cnt++;
            end
            if ($urandom_range(3) != 0)
            begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(8, 1)) @(negedge clk);
            end
        end
    endtask

    // Receiver: stall rate changes from phase to phase; a long hold on request.
    initial
    begin
        int unsigned stall_pct;
        int unsigned phase_left;
        m_tready   = 1'b0;
        stall_pct  = 0;
        phase_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                m_tready = 1'b0;
                repeat (60) @(negedge clk);
                long_hold_req = 1'b0;
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(80, 16);
                case ($urandom_range(4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 85;
                endcase
            end
            phase_left--;
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("FAIL supply_voltage_monitor");
        $finish;
    end

    initial
    begin
        int unsigned p;
        int unsigned k;
        logic [15:0] w;
        logic [15:0] c;
        logic [15:0] wd;
        logic [15:0] rd;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        long_hold_req = 1'b0;
        sent          = 0;
        settings      = 1;
        cur_warn      = RstWarnLevel;
        cur_clear     = RstClearLevel;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // unused indexes must leave every register alone
        write_reg(RegSpare6, 16'h0000);
        write_reg(RegSpare7, 16'hFFFF);

        // reset settings: seeding, field extremes, both sides of each level
        send_sample(16'd12000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'd11800, 1'b0);
        send_sample(16'd11799, 1'b1);
        send_sample(16'd12200, 1'b0);
        send_sample(16'd12199, 1'b1);
        send_sample(16'hFFFF, 1'b1);

        // zero dwells, pass-through filters, equal levels
        drain_monitor();
        set_config(16'd12000, 16'd12000, 16'd0, 16'd0, 4'd0, 4'd0);
        send_sample(16'd11999, 1'b1);
        send_sample(16'd12000, 1'b0);
        send_sample(16'd11000, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd0, 1'b0);

        // crossed levels at the extremes, slowest filters, longest dwells
        drain_monitor();
        set_config(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 4'd15, 4'd15);
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd1, 1'b0);
        send_sample(16'hFFFE, 1'b1);

        drain_monitor();
        set_config(16'd0, 16'hFFFF, 16'd1, 16'd1, 4'd1, 4'd1);
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h5A5A, 1'b1);

        for (p = 0; p < 8; p++)
        begin
            drain_monitor();
            case (p)
                0: set_config(16'd11800, 16'd12200, 16'd3, 16'd2, 4'd2, 4'd1);
                6: set_config(16'd12000, 16'd12600, 16'd4, 16'd0, 4'd15, 4'd15);
                7: set_config(16'd11800, 16'd12200, 16'hFFFF, 16'hFFFF, 4'd0, 4'd3);
                default:
                begin
                    w = 16'(6000 + $urandom_range(8000));
                    if ($urandom_range(3) == 0)
                        c = w - 16'($urandom_range(500));
                    else
                        c = w + 16'($urandom_range(1000));
                    wd = ($urandom_range(7) == 0) ? 16'd150 : 16'($urandom_range(10));
                    rd = ($urandom_range(7) == 0) ? 16'd100 : 16'($urandom_range(10));
                    set_config(w, c, wd, rd, 4'($urandom_range(5)), 4'($urandom_range(6)));
                end
            endcase

            if (p == 3)
            begin
                // receiver holds off while requests keep coming, filling the pipe
                long_hold_req = 1'b1;
                for (k = 0; k < 16; k++)
                    send_sample(cur_warn + 16'($urandom_range(400)) - 16'd200,
                                1'($urandom));
                run_random(50);
            end
            else if (p == 5)
            begin
                run_random(33);
                drain_monitor();
                run_random(33);
            end
            else
            begin
                run_random(66);
            end
        end

        drain_monitor();
        repeat (10) @(negedge clk);
        $display("Ran %0d samples over %0d register settings; %0d results compared.",
                 sent, settings, checked);
        $display("Warning was raised on %0d of those results.", warn_seen);
        if (errors == 0 && pending == 0)
            $display("PASS supply_voltage_monitor");
        else
            $display("FAIL supply_voltage_monitor");
        $finish;
    end

endmodule
